/* hw/rtl/wscm_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket client frame masker package
// Shared types, constants and helpers for the frame masker front, queue and
// back end.
// ----------------------------------------------------------------------------
package wscm_pkg;

  localparam int unsigned LenW     = 63;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 104;  // 103 payload bits padded to bytes
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned HdrIdxW  = 4;

  localparam logic [ByteW-1:0] HdrFinText = 8'h81;
  localparam logic [ByteW-1:0] LenMaskBit = 8'h80;
  localparam logic [LenW-1:0]  LenShortMax = 63'd125;
  localparam logic [LenW-1:0]  LenMidMax   = 63'd65535;
  localparam logic [6:0]       LenCode16   = 7'd126;
  localparam logic [6:0]       LenCode64   = 7'd127;

  // Item kinds on the input tuser bit.
  localparam logic KindStart   = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_MID   = 2'd1,
    LEN_LONG  = 2'd2
  } len_form_e;

  // One queued command: either a whole header or one masked payload byte.
  typedef struct packed {
    logic             is_hdr;
    len_form_e        form;
    logic [LenW-1:0]  len;
    logic [KeyW-1:0]  key;
    logic [ByteW-1:0] data;
    logic             eof;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Key byte for a phase; phase 0 is the first-sent byte in bits 31:24.
  function automatic logic [ByteW-1:0] key_byte(input logic [KeyW-1:0] key,
                                                input logic [1:0] phase);
    logic [KeyW-1:0] shifted;
    shifted = key << {phase, 3'b000};
    return shifted[KeyW-1 -: ByteW];
  endfunction

endpackage

/* hw/rtl/wscm_front.sv */
// ----------------------------------------------------------------------------
// Frame masker front end
// Accepts input items, tracks key phase and remaining length, masks payload
// bytes and queues one command per item that produces output.
// ----------------------------------------------------------------------------
module wscm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [wscm_pkg::LenW-1:0]     payload_length_i,
  input  logic [wscm_pkg::KeyW-1:0]     frame_key_i,
  input  logic [wscm_pkg::ByteW-1:0]    payload_byte_i,
  output logic                          push_o,
  output wscm_pkg::cmd_t                cmd_o,
  input  logic                          q_full_i
);

  logic [wscm_pkg::KeyW-1:0] key_q, key_d;
  logic [1:0]                phase_q, phase_d;
  logic [wscm_pkg::LenW-1:0] left_q, left_d;
  logic                      accept;
  logic                      left_zero;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign left_zero  = (left_q == '0);

  always_comb begin
    key_d    = key_q;
    phase_d  = phase_q;
    left_d   = left_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    if (accept) begin
      if (kind_i == wscm_pkg::KindStart) begin
        key_d       = frame_key_i;
        phase_d     = 2'd0;
        left_d      = payload_length_i;
        push_o      = 1'b1;
        cmd_o.is_hdr = 1'b1;
        cmd_o.len   = payload_length_i;
        cmd_o.key   = frame_key_i;
        cmd_o.eof   = (payload_length_i == '0);
        if (payload_length_i <= wscm_pkg::LenShortMax) begin
          cmd_o.form = wscm_pkg::LEN_SHORT;
        end else if (payload_length_i <= wscm_pkg::LenMidMax) begin
          cmd_o.form = wscm_pkg::LEN_MID;
        end else begin
          cmd_o.form = wscm_pkg::LEN_LONG;
        end
      end else if (!left_zero) begin
        // Bytes beyond the declared length are dropped without a command.
        phase_d    = phase_q + 2'd1;
        left_d     = left_q - wscm_pkg::LenW'(1);
        push_o     = 1'b1;
        cmd_o.data = payload_byte_i ^ wscm_pkg::key_byte(key_q, phase_q);
        cmd_o.eof  = (left_q == wscm_pkg::LenW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      phase_q <= 2'd0;
      left_q  <= '0;
    end else begin
      key_q   <= key_d;
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

/* hw/rtl/wscm_queue.sv */
// ----------------------------------------------------------------------------
// Frame masker command queue
// Small first-in first-out buffer of commands between front and back end.
// ----------------------------------------------------------------------------
module wscm_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wscm_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output wscm_pkg::cmd_t       cmd_o,
  output logic                 valid_o,
  output wscm_pkg::q_status_t  status_o
);

  wscm_pkg::cmd_t               slots_q [wscm_pkg::QDepth];
  logic [wscm_pkg::QAw-1:0]     wr_ptr_q, rd_ptr_q;
  logic [wscm_pkg::QCntW-1:0]   count_q, count_d;
  logic                         do_push, do_pop;

  assign status_o.full  = (count_q == wscm_pkg::QCntW'(wscm_pkg::QDepth));
  assign status_o.empty = (count_q == '0);
  assign valid_o        = !status_o.empty;
  assign cmd_o          = slots_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + wscm_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - wscm_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + wscm_pkg::QAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + wscm_pkg::QAw'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hw/rtl/wscm_back.sv */
// ----------------------------------------------------------------------------
// Frame masker back end
// Expands header commands into frame bytes, one per cycle unless the output
// stalls; passes masked payload bytes through and holds the output register.
// ----------------------------------------------------------------------------
module wscm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wscm_pkg::cmd_t                cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wscm_pkg::ByteW-1:0]    out_byte_o,
  output logic                          end_of_run_o,
  output logic                          end_of_frame_o
);

  logic [wscm_pkg::HdrIdxW-1:0] idx_q, idx_d;
  logic                         valid_q, valid_d;
  logic [wscm_pkg::ByteW-1:0]   byte_q, byte_d;
  logic                         run_q, run_d;
  logic                         eof_q, eof_d;

  logic                         emit;
  logic [wscm_pkg::HdrIdxW-1:0] ext;
  logic [wscm_pkg::HdrIdxW-1:0] last_idx;
  logic [wscm_pkg::HdrIdxW-1:0] len_k;
  logic [wscm_pkg::HdrIdxW-1:0] key_k;
  logic [63:0]                  len64;
  logic [63:0]                  len_shift;
  logic [wscm_pkg::ByteW-1:0]   hdr_byte;
  logic                         hdr_last;

  assign emit  = cmd_valid_i && (!valid_q || out_ready_i);
  assign len64 = {1'b0, cmd_i.len};
  assign len_k = idx_q - wscm_pkg::HdrIdxW'(2);
  assign key_k = idx_q - wscm_pkg::HdrIdxW'(2) - ext;
  assign len_shift = len64 << {len_k[2:0], 3'b000};
  assign last_idx  = wscm_pkg::HdrIdxW'(5) + ext;
  assign hdr_last  = (idx_q == last_idx);

  // Extended length bytes that follow the second header byte.
  always_comb begin
    unique case (cmd_i.form)
      wscm_pkg::LEN_SHORT: ext = wscm_pkg::HdrIdxW'(0);
      wscm_pkg::LEN_MID:   ext = wscm_pkg::HdrIdxW'(2);
      wscm_pkg::LEN_LONG:  ext = wscm_pkg::HdrIdxW'(8);
      default:             ext = wscm_pkg::HdrIdxW'(0);
    endcase
  end

  always_comb begin
    priority if (idx_q == '0) begin
      hdr_byte = wscm_pkg::HdrFinText;
    end else if (idx_q == wscm_pkg::HdrIdxW'(1)) begin
      unique case (cmd_i.form)
        wscm_pkg::LEN_SHORT: hdr_byte = wscm_pkg::LenMaskBit | {1'b0, cmd_i.len[6:0]};
        wscm_pkg::LEN_MID:   hdr_byte = wscm_pkg::LenMaskBit | {1'b0, wscm_pkg::LenCode16};
        wscm_pkg::LEN_LONG:  hdr_byte = wscm_pkg::LenMaskBit | {1'b0, wscm_pkg::LenCode64};
        default:             hdr_byte = wscm_pkg::LenMaskBit;
      endcase
    end else if (idx_q < wscm_pkg::HdrIdxW'(2) + ext) begin
      if (cmd_i.form == wscm_pkg::LEN_MID) begin
        hdr_byte = len_k[0] ? cmd_i.len[7:0] : cmd_i.len[15:8];
      end else begin
        hdr_byte = len_shift[63 -: 8];
      end
    end else begin
      hdr_byte = wscm_pkg::key_byte(cmd_i.key, key_k[1:0]);
    end
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    run_d   = run_q;
    eof_d   = eof_q;
    pop_o   = 1'b0;
    if (emit) begin
      valid_d = 1'b1;
      if (cmd_i.is_hdr) begin
        byte_d = hdr_byte;
        run_d  = hdr_last;
        eof_d  = hdr_last && cmd_i.eof;
        pop_o  = hdr_last;
        idx_d  = hdr_last ? '0 : idx_q + wscm_pkg::HdrIdxW'(1);
      end else begin
        byte_d = cmd_i.data;
        run_d  = 1'b1;
        eof_d  = cmd_i.eof;
        pop_o  = 1'b1;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    run_q  <= run_d;
    eof_q  <= eof_d;
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign end_of_run_o   = run_q;
  assign end_of_frame_o = eof_q;

endmodule

/* hw/rtl/websocket_client_frame_masker_core.sv */
// ----------------------------------------------------------------------------
// WebSocket client frame masker
// Builds masked single-fragment client text frames from a start item and a
// stream of payload bytes.
// ----------------------------------------------------------------------------
// A start item produces the 0x81 header, the masked length (6, 8 or 14 bytes
// in all with the four key bytes) at one byte per cycle unless the output
// stalls; each payload item leaves as one masked byte, so payload streams at
// one item per cycle. The back end's output rate of one byte per cycle, when
// not stalled, sets the throughput; a four-entry command queue lets the input
// keep accepting while a header is being sent or the output is stalled.
// Payload bytes beyond the declared length are dropped, making no output item.
module websocket_client_frame_masker_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // payload_length [62:0], frame_key [94:63], payload_byte [102:95], zero [103]
  input  logic [103:0] s_axis_tdata_i,
  // kind [0]
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_byte [7:0]
  output logic [7:0]   m_axis_tdata_o,
  // end_of_run [0]
  output logic         m_axis_tuser_o,
  // end_of_frame
  output logic         m_axis_tlast_o
);

  logic                 push;
  wscm_pkg::cmd_t       push_cmd;
  wscm_pkg::cmd_t       head_cmd;
  logic                 head_valid;
  logic                 pop;
  wscm_pkg::q_status_t  q_status;

  wscm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .kind_i           (s_axis_tuser_i),
    .payload_length_i (s_axis_tdata_i[62:0]),
    .frame_key_i      (s_axis_tdata_i[94:63]),
    .payload_byte_i   (s_axis_tdata_i[102:95]),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .q_full_i         (q_status.full)
  );

  wscm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .valid_o  (head_valid),
    .status_o (q_status)
  );

  wscm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .cmd_valid_i    (head_valid),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_byte_o     (m_axis_tdata_o),
    .end_of_run_o   (m_axis_tuser_o),
    .end_of_frame_o (m_axis_tlast_o)
  );

  // The last byte of a frame always closes the run of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o)
    else $error("end of frame without end of run");

  // The input stalls only because the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_status.full)
    else $error("input stalled with room in queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  // A pop always consumes a valid head entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

/* tb/websocket_client_frame_masker_checker.sv */
// ----------------------------------------------------------------------------
// Frame masker checker
// Watches both streams of the frame masker, rebuilds the client frame bytes
// that every accepted item should produce and compares each byte that leaves
// the block, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module websocket_client_frame_masker_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  // payload_length [62:0], frame_key [94:63], payload_byte [102:95], zero [103]
  input  logic [wscm_pkg::InDataW-1:0] s_axis_tdata_i,
  // kind [0]
  input  logic                         s_axis_tuser_i,
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  // out_byte [7:0]
  input  logic [wscm_pkg::ByteW-1:0]   m_axis_tdata_i,
  // end_of_run [0]
  input  logic                         m_axis_tuser_i,
  input  logic                         m_axis_tlast_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  typedef struct packed {
    logic [wscm_pkg::ByteW-1:0] data;
    logic                       run_end;
    logic                       frame_end;
  } wire_byte_t;

  wire_byte_t                owed_bytes[$];
  logic [wscm_pkg::KeyW-1:0] cur_key;
  logic [1:0]                key_idx;
  logic [wscm_pkg::LenW-1:0] bytes_owed;
  int unsigned               fails = 0;
  int unsigned               queued = 0;

  assign fail_count_o = fails;
  assign pending_o    = queued;

  task automatic report_mismatch(input string what);
    $display("checker: %s at %0t", what, $time);
    fails++;
  endtask

  function automatic logic [wscm_pkg::ByteW-1:0] key_lane(
      input logic [wscm_pkg::KeyW-1:0] key, input logic [1:0] idx);
    logic [wscm_pkg::KeyW-1:0] shifted;
    shifted = key >> (8 * (3 - idx));
    return shifted[wscm_pkg::ByteW-1:0];
  endfunction

  task automatic owe_byte(input logic [wscm_pkg::ByteW-1:0] data, input logic run_end,
                          input logic frame_end);
    owed_bytes.push_back('{data, run_end, frame_end});
  endtask

  task automatic predict_frame_bytes(input logic kind,
                                     input logic [wscm_pkg::InDataW-1:0] item);
    logic [wscm_pkg::LenW-1:0]  len;
    logic [63:0]                len64;
    logic [wscm_pkg::ByteW-1:0] masked;
    len = item[wscm_pkg::LenW-1:0];
    if (kind == wscm_pkg::KindStart) begin
      // A start drops whatever is left of the previous frame.
      cur_key    = item[wscm_pkg::LenW +: wscm_pkg::KeyW];
      key_idx    = 2'd0;
      bytes_owed = len;
      owe_byte(wscm_pkg::HdrFinText, 1'b0, 1'b0);
      if (len <= wscm_pkg::LenShortMax) begin
        owe_byte(wscm_pkg::LenMaskBit | {1'b0, len[6:0]}, 1'b0, 1'b0);
      end else if (len <= wscm_pkg::LenMidMax) begin
        owe_byte(wscm_pkg::LenMaskBit | {1'b0, wscm_pkg::LenCode16}, 1'b0, 1'b0);
        owe_byte(len[15:8], 1'b0, 1'b0);
        owe_byte(len[7:0], 1'b0, 1'b0);
      end else begin
        owe_byte(wscm_pkg::LenMaskBit | {1'b0, wscm_pkg::LenCode64}, 1'b0, 1'b0);
        len64 = {1'b0, len};
        for (int i = 0; i < 8; i++) owe_byte(len64[63 - 8 * i -: 8], 1'b0, 1'b0);
      end
      for (int i = 0; i < 4; i++) begin
        owe_byte(key_lane(cur_key, 2'(i)), i == 3, (i == 3) && (len == '0));
      end
    end else if (bytes_owed != '0) begin
      masked = item[wscm_pkg::LenW + wscm_pkg::KeyW +: wscm_pkg::ByteW] ^
               key_lane(cur_key, key_idx);
      key_idx++;
      bytes_owed--;
      owe_byte(masked, 1'b1, bytes_owed == '0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wire_byte_t want;
    if (!rst_ni) begin
      cur_key    = '0;
      key_idx    = 2'd0;
      bytes_owed = '0;
      owed_bytes.delete();
      queued     = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_frame_bytes(s_axis_tuser_i, s_axis_tdata_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (owed_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata_i));
        end else begin
          want = owed_bytes.pop_front();
          if (m_axis_tdata_i !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata_i,
                                      want.data));
          end
          if (m_axis_tuser_i !== want.run_end) begin
            report_mismatch($sformatf("end_of_run %b, want %b", m_axis_tuser_i,
                                      want.run_end));
          end
          if (m_axis_tlast_i !== want.frame_end) begin
            report_mismatch($sformatf("end_of_frame %b, want %b", m_axis_tlast_i,
                                      want.frame_end));
          end
        end
      end
      queued = owed_bytes.size();
    end
  end

endmodule

/* tb/tb_websocket_client_frame_masker_core.sv */
// ----------------------------------------------------------------------------
// Frame masker testbench
// Sends start and payload items to the client frame masker, first a directed
// set of length forms, keys and frame edge cases, then random messages, some
// complete, some cut short and some with excess bytes, under several patterns
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_websocket_client_frame_masker_core;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned DrainCycles = 32;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [wscm_pkg::InDataW-1:0] s_tdata = '0;
  logic                         s_tuser = wscm_pkg::KindStart;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [wscm_pkg::ByteW-1:0]   m_tdata;
  logic                         m_tuser;
  logic                         m_tlast;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt;
  int unsigned bytes_pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  websocket_client_frame_masker_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  websocket_client_frame_masker_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (fail_cnt),
    .pending_o       (bytes_pending)
  );

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [wscm_pkg::LenW-1:0] rand_len();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[wscm_pkg::LenW-1:0];
  endfunction

  // Called just after a rising edge; the item is held until it is taken.
  task automatic send_item(input logic kind, input logic [wscm_pkg::LenW-1:0] len,
                           input logic [wscm_pkg::KeyW-1:0] key,
                           input logic [wscm_pkg::ByteW-1:0] pbyte);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, pbyte, key, len};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Fields that the item kind does not use carry random values.
  task automatic send_start(input logic [wscm_pkg::LenW-1:0] len,
                            input logic [wscm_pkg::KeyW-1:0] key);
    send_item(wscm_pkg::KindStart, len, key, wscm_pkg::ByteW'($urandom));
  endtask

  task automatic send_byte(input logic [wscm_pkg::ByteW-1:0] pbyte);
    send_item(wscm_pkg::KindPayload, rand_len(), $urandom, pbyte);
  endtask

  task automatic send_random_message();
    logic [wscm_pkg::LenW-1:0] len;
    int unsigned               sel;
    int unsigned               n;
    if ($urandom_range(99) < 4) send_byte(wscm_pkg::ByteW'($urandom));
    sel = $urandom_range(99);
    if (sel < 50) begin
      len = wscm_pkg::LenW'($urandom_range(8));
    end else if (sel < 68) begin
      len = wscm_pkg::LenW'($urandom_range(125, 9));
    end else if (sel < 78) begin
      len = wscm_pkg::LenW'($urandom_range(65535, 126));
    end else if (sel < 86) begin
      len = rand_len();
      if (len <= wscm_pkg::LenMidMax) len[40] = 1'b1;
    end else if (sel < 94) begin
      case ($urandom_range(5))
        0:       len = '0;
        1:       len = wscm_pkg::LenShortMax;
        2:       len = wscm_pkg::LenShortMax + 1;
        3:       len = wscm_pkg::LenMidMax;
        4:       len = wscm_pkg::LenMidMax + 1;
        default: len = '1;
      endcase
    end else begin
      len = rand_len();
    end
    // Long frames are abandoned early by the next start.
    if (len > 40) begin
      n = $urandom_range(8);
    end else begin
      sel = $urandom_range(99);
      if (sel < 75) n = int'(len);
      else if (sel < 87) n = int'(len) + $urandom_range(3, 1);
      else n = $urandom_range(int'(len));
    end
    send_start(len, $urandom);
    repeat (n) send_byte(wscm_pkg::ByteW'($urandom));
  endtask

  initial begin
    int unsigned directed_cnt;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with no idling on either side.
    send_byte(8'h5a);                      // nothing owed after reset
    send_start('0, 32'hffff_ffff);         // empty payload
    send_byte(8'hff);                      // excess byte
    send_start(wscm_pkg::LenShortMax, 32'h0000_0000);
    send_start(wscm_pkg::LenShortMax + 1, 32'h1234_5678);
    send_start(wscm_pkg::LenMidMax, 32'h8000_0001);
    send_start(wscm_pkg::LenMidMax + 1, 32'hdead_beef);
    send_start('1, 32'hffff_ffff);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(8'h01);                      // key index wraps
    send_start(63'd3, 32'h0102_0304);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7f);                      // beyond the declared length
    send_start(63'd5, 32'ha5c3_0f96);
    repeat (5) send_byte(wscm_pkg::ByteW'($urandom));
    directed_cnt = items_sent;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      while (items_sent < directed_cnt + (ph + 1) * RandomItems / 4) begin
        send_random_message();
      end
    end

    @(negedge clk) s_tvalid <= 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* websocket_client_frame_masker_core.f */
hw/rtl/wscm_pkg.sv
hw/rtl/wscm_front.sv
hw/rtl/wscm_queue.sv
hw/rtl/wscm_back.sv
hw/rtl/websocket_client_frame_masker_core.sv
tb/websocket_client_frame_masker_checker.sv
tb/tb_websocket_client_frame_masker_core.sv
